// File: src/dlp_pkg.sv
`default_nettype none

package dlp_pkg;

  localparam int MAX_ITEMS   = 127;
  localparam int TOKEN_CHARS = 15;

  localparam int KEPT_W  = $clog2(TOKEN_CHARS + 1);
  localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 7;
  localparam int CFG_IDX_W = 1;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic signed [DATA_W-1:0] MAX_VALUE_RESET = 32'sd16383;
  localparam logic signed [DATA_W-1:0] MIN_VALUE_RESET = -32'sd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_VALUE = 1'b0,
    REG_MIN_VALUE = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_NUMBER = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_EXPECT = 2'd0,
    PH_TOKEN  = 2'd1,
    PH_AFTER  = 2'd2
  } phase_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [DATA_W-1:0] value;
    logic [COUNT_W-1:0]       count;
    logic                     end_flag;
  } result_t;

  // up to two results per character: a number, then the line status
  typedef struct packed {
    logic    num_valid;
    result_t num;
    logic    stat_valid;
    result_t stat;
  } push_t;

endpackage

`default_nettype wire

// File: src/dlp_char_if.sv
`default_nettype none

interface dlp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

`default_nettype wire

// File: src/dlp_result_if.sv
`default_nettype none

interface dlp_result_if;
  logic                 valid;
  logic                 ready;
  dlp_pkg::kind_t       kind;
  logic signed [31:0]   value;
  logic [6:0]           count;
  logic                 end_flag;

  modport source (output valid, output kind, output value, output count, output end_flag,
                  input ready);
  modport sink   (input valid, input kind, input value, input count, input end_flag,
                  output ready);
endinterface

`default_nettype wire

// File: src/dlp_out_fifo.sv
`default_nettype none

module dlp_out_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire dlp_pkg::push_t push,
  output logic               room,
  dlp_result_if.source       results
);
  import dlp_pkg::*;

  result_t           mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  tail;
  logic [FILL_W-1:0] fill;

  logic [PTR_W-1:0]  stat_addr;
  logic [1:0]        push_cnt;
  logic              pop;

  assign pop       = results.valid && results.ready;
  assign push_cnt  = 2'(push.num_valid) + 2'(push.stat_valid);
  assign stat_addr = tail + PTR_W'(push.num_valid);
  assign room      = fill <= FILL_W'(FIFO_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.num_valid) begin
      mem[tail] <= push.num;
    end
    if (push.stat_valid) begin
      mem[stat_addr] <= push.stat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      tail <= tail + PTR_W'(push_cnt);
      if (pop) begin
        head <= head + PTR_W'(1);
      end
      fill <= fill + FILL_W'(push_cnt) - FILL_W'(pop);
    end
  end

  assign results.valid    = fill != '0;
  assign results.kind     = mem[head].kind;
  assign results.value    = mem[head].value;
  assign results.count    = mem[head].count;
  assign results.end_flag = mem[head].end_flag;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(FIFO_DEPTH))
    else $error("output queue overfilled");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    (push.num_valid || push.stat_valid) |-> room)
    else $error("push without room");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> fill != '0)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// File: src/decimal_list_parser.sv
`default_nettype none

// Each result is registered in the output queue and is shown once it reaches the queue head.
// Throughput: one character per cycle; the four-entry output queue takes a new
//   character only while two entries are free, so the rate follows the output side.
// A character may cause two results (number, then line status).
// Reset (synchronous, rst high): line state cleared, queue emptied, registers to defaults.
module decimal_list_parser (
  input  wire logic                           clk,
  input  wire logic                           rst,
  dlp_char_if.sink                            chars,
  dlp_result_if.source                        results,
  input  wire logic                           cfg_we,
  input  wire logic [dlp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dlp_pkg::DATA_W-1:0]     cfg_data
);
  import dlp_pkg::*;

  logic signed [DATA_W-1:0] max_value;
  logic signed [DATA_W-1:0] min_value;

  phase_t             phase;
  logic               negative;
  logic               sign_seen;
  logic [KEPT_W-1:0]  kept_chars;
  logic               token_bad;
  logic [DATA_W-1:0]  magnitude;
  logic               overflow;
  logic [CNT_W-1:0]   number_count;
  logic               rejected;

  phase_t             phase_next;
  logic               negative_next;
  logic               sign_seen_next;
  logic [KEPT_W-1:0]  kept_chars_next;
  logic               token_bad_next;
  logic [DATA_W-1:0]  magnitude_next;
  logic               overflow_next;
  logic [CNT_W-1:0]   number_count_next;
  logic               rejected_next;

  push_t              push;
  logic               room;
  logic               accept;

  logic               is_comma;
  logic               is_space;
  logic               is_digit;
  logic               is_sign;
  logic [DATA_W+3:0]  prod;

  assign accept   = chars.valid && chars.ready;
  assign is_comma = chars.ch == CH_COMMA;
  assign is_space = chars.ch == CH_SPACE || (chars.ch >= CH_TAB && chars.ch <= CH_CR);
  assign is_digit = chars.ch >= CH_ZERO && chars.ch <= CH_NINE;
  assign is_sign  = chars.ch == CH_PLUS || chars.ch == CH_MINUS;
  // magnitude * 10 + digit
  assign prod = {1'b0, magnitude, 3'b000} + {3'b000, magnitude, 1'b0}
              + (DATA_W+4)'(chars.ch[3:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_value <= MAX_VALUE_RESET;
      min_value <= MIN_VALUE_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MAX_VALUE: max_value <= cfg_data;
        REG_MIN_VALUE: min_value <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic                  tc_en;
    logic                  fin_en;
    logic                  no_digits;
    logic signed [DATA_W:0] v;

    phase_next        = phase;
    negative_next     = negative;
    sign_seen_next    = sign_seen;
    kept_chars_next   = kept_chars;
    token_bad_next    = token_bad;
    magnitude_next    = magnitude;
    overflow_next     = overflow;
    number_count_next = number_count;
    rejected_next     = rejected;
    tc_en             = 1'b0;
    fin_en            = 1'b0;
    no_digits         = 1'b0;
    v                 = '0;
    push              = '0;

    if (!rejected) begin
      unique case (phase)
        PH_EXPECT: begin
          if (is_comma) begin
            rejected_next = 1'b1;
          end else if (!is_space) begin
            phase_next = PH_TOKEN;
            tc_en      = 1'b1;
          end
        end
        PH_TOKEN: begin
          if (is_comma || is_space) begin
            fin_en     = 1'b1;
            phase_next = is_comma ? PH_EXPECT : PH_AFTER;
          end else begin
            tc_en = 1'b1;
          end
        end
        PH_AFTER: begin
          if (is_comma) begin
            phase_next = PH_EXPECT;
          end else if (!is_space) begin
            rejected_next = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // characters past the kept window are dropped
    if (tc_en && kept_chars < KEPT_W'(TOKEN_CHARS)) begin
      if (kept_chars == '0 && is_sign) begin
        sign_seen_next = 1'b1;
        negative_next  = chars.ch == CH_MINUS;
      end else if (is_digit) begin
        if (!overflow) begin
          if (prod[DATA_W+3:DATA_W] != '0) begin
            overflow_next = 1'b1;
          end else begin
            magnitude_next = prod[DATA_W-1:0];
          end
        end
      end else begin
        token_bad_next = 1'b1;
      end
      kept_chars_next = kept_chars + KEPT_W'(1);
    end

    if (chars.last && !rejected_next) begin
      if (phase_next == PH_EXPECT) begin
        rejected_next = 1'b1;
      end else if (phase_next == PH_TOKEN) begin
        fin_en = 1'b1;
      end
    end

    if (fin_en) begin
      v = negative_next ? -$signed({1'b0, magnitude_next}) : $signed({1'b0, magnitude_next});
      no_digits = kept_chars_next == '0 || (sign_seen_next && kept_chars_next == KEPT_W'(1));
      if (token_bad_next || no_digits || overflow_next
          || v > $signed({max_value[DATA_W-1], max_value})
          || v < $signed({min_value[DATA_W-1], min_value})
          || number_count >= CNT_W'(MAX_ITEMS)) begin
        rejected_next = 1'b1;
      end else begin
        number_count_next       = number_count + CNT_W'(1);
        push.num_valid          = 1'b1;
        push.num.kind           = KIND_NUMBER;
        push.num.value          = v[DATA_W-1:0];
        push.num.count          = COUNT_W'(number_count_next);
        push.num.end_flag       = 1'b0;
      end
      negative_next   = 1'b0;
      sign_seen_next  = 1'b0;
      kept_chars_next = '0;
      token_bad_next  = 1'b0;
      magnitude_next  = '0;
      overflow_next   = 1'b0;
    end

    if (chars.last) begin
      push.stat_valid    = 1'b1;
      push.stat.kind     = rejected_next ? KIND_REJECT : KIND_ACCEPT;
      push.stat.value    = '0;
      push.stat.count    = COUNT_W'(number_count_next);
      push.stat.end_flag = 1'b1;
      phase_next         = PH_EXPECT;
      negative_next      = 1'b0;
      sign_seen_next     = 1'b0;
      kept_chars_next    = '0;
      token_bad_next     = 1'b0;
      magnitude_next     = '0;
      overflow_next      = 1'b0;
      number_count_next  = '0;
      rejected_next      = 1'b0;
    end

    if (!accept) begin
      push.num_valid  = 1'b0;
      push.stat_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_EXPECT;
      negative     <= 1'b0;
      sign_seen    <= 1'b0;
      kept_chars   <= '0;
      token_bad    <= 1'b0;
      magnitude    <= '0;
      overflow     <= 1'b0;
      number_count <= '0;
      rejected     <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      negative     <= negative_next;
      sign_seen    <= sign_seen_next;
      kept_chars   <= kept_chars_next;
      token_bad    <= token_bad_next;
      magnitude    <= magnitude_next;
      overflow     <= overflow_next;
      number_count <= number_count_next;
      rejected     <= rejected_next;
    end
  end

  assign chars.ready = room;

  dlp_out_fifo u_out_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .room    (room),
    .results (results)
  );

`ifndef SYNTH
  a_line_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && chars.last) |=> (phase == PH_EXPECT && number_count == '0 && !rejected))
    else $error("line state not cleared after last character");

  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    kept_chars <= KEPT_W'(TOKEN_CHARS))
    else $error("kept character count beyond window");

  a_no_number_after_reject: assert property (@(posedge clk) disable iff (rst)
    push.num_valid |-> !rejected)
    else $error("number emitted on a rejected line");

  a_status_only_on_last: assert property (@(posedge clk) disable iff (rst)
    push.stat_valid |-> (accept && chars.last))
    else $error("status without last character");
`endif

endmodule

`default_nettype wire

// File: bench/list_check_pkg.sv
package list_check_pkg;
  import dlp_pkg::*;

  class parse_scoreboard;
    result_t     expected_q[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned numbers_seen;
    int unsigned lists_accepted;
    int unsigned lists_rejected;

    longint      max_v;
    longint      min_v;

    phase_t      phase;
    bit          negative;
    bit          sign_seen;
    bit          token_bad;
    bit          overflowed;
    bit          rejected;
    int unsigned kept;
    int unsigned count;
    logic [31:0] mag;

    function new();
      set_defaults();
    endfunction

    function void set_defaults();
      max_v = MAX_VALUE_RESET;
      min_v = MIN_VALUE_RESET;
      clear_line();
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] d);
      case (idx)
        REG_MAX_VALUE: max_v = $signed(d);
        REG_MIN_VALUE: min_v = $signed(d);
        default: ;
      endcase
    endfunction

    function void clear_token();
      negative   = 1'b0;
      sign_seen  = 1'b0;
      token_bad  = 1'b0;
      overflowed = 1'b0;
      kept       = 0;
      mag        = '0;
    endfunction

    function void clear_line();
      clear_token();
      phase    = PH_EXPECT;
      count    = 0;
      rejected = 1'b0;
    endfunction

    function bit is_space(byte unsigned c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function void add_result(kind_t k, logic [31:0] v, bit e);
      result_t r;
      r.kind     = k;
      r.value    = v;
      r.count    = count[COUNT_W-1:0];
      r.end_flag = e;
      expected_q.push_back(r);
    endfunction

    function void take_token_char(byte unsigned c);
      logic [63:0] m;
      if (kept >= TOKEN_CHARS) return;
      if (kept == 0 && (c == CH_PLUS || c == CH_MINUS)) begin
        sign_seen = 1'b1;
        negative  = (c == CH_MINUS);
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
        if (!overflowed) begin
          m = {32'd0, mag} * 64'd10 + 64'(c - CH_ZERO);
          if (m > 64'hFFFF_FFFF) overflowed = 1'b1;
          else mag = m[31:0];
        end
      end else begin
        token_bad = 1'b1;
      end
      kept++;
    endfunction

    function void close_token();
      longint v;
      bit     no_digits;
      v = longint'({32'd0, mag});
      if (negative) v = -v;
      no_digits = (kept == 0) || (sign_seen && kept == 1);
      if (token_bad || no_digits || overflowed || v > max_v || v < min_v ||
          count >= MAX_ITEMS) begin
        rejected = 1'b1;
      end else begin
        count++;
        add_result(KIND_NUMBER, v[31:0], 1'b0);
      end
      clear_token();
    endfunction

    // one character transfer into the parser
    function void note_char(byte unsigned c, bit is_last);
      if (!rejected) begin
        case (phase)
          PH_EXPECT: begin
            if (c == CH_COMMA) rejected = 1'b1;
            else if (!is_space(c)) begin
              phase = PH_TOKEN;
              take_token_char(c);
            end
          end
          PH_TOKEN: begin
            if (c == CH_COMMA || is_space(c)) begin
              close_token();
              phase = (c == CH_COMMA) ? PH_EXPECT : PH_AFTER;
            end else begin
              take_token_char(c);
            end
          end
          default: begin
            if (c == CH_COMMA) phase = PH_EXPECT;
            else if (!is_space(c)) rejected = 1'b1;
          end
        endcase
      end
      if (is_last) begin
        if (!rejected) begin
          if (phase == PH_EXPECT) rejected = 1'b1;
          else if (phase == PH_TOKEN) close_token();
        end
        add_result(rejected ? KIND_REJECT : KIND_ACCEPT, '0, 1'b1);
        clear_line();
      end
    endfunction

    task report(string msg);
      $display("ERROR: result %0d: %s", results_seen, msg);
      mismatches++;
    endtask

    task check_result(result_t got);
      result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected: kind %0d value %0d count %0d end %0d",
                         got.kind, got.value, got.count, got.end_flag));
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.value !== want.value)
        report($sformatf("value %0d, expected %0d", got.value, want.value));
      if (got.count !== want.count)
        report($sformatf("count %0d, expected %0d", got.count, want.count));
      if (got.end_flag !== want.end_flag)
        report($sformatf("end_flag %0d, expected %0d", got.end_flag, want.end_flag));
      case (got.kind)
        KIND_NUMBER: numbers_seen++;
        KIND_ACCEPT: lists_accepted++;
        default:     lists_rejected++;
      endcase
    endtask
  endclass

endpackage

// File: bench/tb_decimal_list_parser.sv
module tb_decimal_list_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import dlp_pkg::*;
  import list_check_pkg::*;

  localparam int CYCLE_LIMIT    = 300000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int CHARS_PER_STEP = 185;
  localparam int NUM_SETTINGS   = 6;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  dlp_char_if   chars_if();
  dlp_result_if res_if();

  parse_scoreboard sb = new();

  bit           steady;
  byte unsigned line_buf[$];
  int unsigned  chars_sent;
  int unsigned  lines_sent;

  decimal_list_parser u_top (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars_if),
    .results   (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("decimal_list_parser regression: fail");
    $finish;
  end

  // result side: random back-pressure, check every transfer
  initial begin
    result_t got;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready) begin
        got.kind     = res_if.kind;
        got.value    = res_if.value;
        got.count    = res_if.count;
        got.end_flag = res_if.end_flag;
        sb.check_result(got);
      end
      res_if.ready <= steady || ($urandom_range(99) >= 30);
    end
  end

  task automatic send_char(input byte unsigned c, input bit is_last);
    while (!steady && $urandom_range(99) < 30) begin
      chars_if.valid <= 1'b0;
      @(posedge clk);
    end
    chars_if.valid <= 1'b1;
    chars_if.ch    <= c;
    chars_if.last  <= is_last;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    sb.note_char(c, is_last);
    chars_sent++;
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
    lines_sent++;
  endtask

  task automatic send_text(input string s);
    line_buf.delete();
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    send_line();
  endtask

  // numbers run past the item limit when n exceeds MAX_ITEMS
  task automatic send_long_list(input int n);
    line_buf.delete();
    for (int i = 0; i < n; i++) begin
      if (i > 0) line_buf.push_back(CH_COMMA);
      line_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
    end
    send_line();
  endtask

  task automatic wait_idle();
    chars_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_limits(input logic [31:0] hi, input logic [31:0] lo);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_VALUE;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_index <= REG_MIN_VALUE;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_reg(REG_MAX_VALUE, hi);
    sb.set_reg(REG_MIN_VALUE, lo);
  endtask

  function automatic byte unsigned ws_char();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
  endfunction

  function automatic byte unsigned junk_char();
    case ($urandom_range(4))
      0: return CH_COMMA;
      1: return CH_PLUS;
      2: return CH_MINUS;
      3: return CH_SPACE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void add_number();
    longint          v;
    longint unsigned span;
    longint unsigned mag;
    string           txt;
    int              r;
    int              len;
    r = $urandom_range(99);
    if (r >= 97) begin
      // long digit run, usually past 32 bits
      len = $urandom_range(10, 14);
      line_buf.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
      repeat (len - 1) line_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
      return;
    end
    if (r < 70 && sb.min_v <= sb.max_v) begin
      span = longint'(sb.max_v - sb.min_v);
      case ($urandom_range(3))
        0: v = sb.min_v;
        1: v = sb.max_v;
        default: v = sb.min_v + longint'({$urandom, $urandom} % (span + 1));
      endcase
    end else if (r < 80) begin
      v = longint'($urandom_range(40)) - 20;
    end else if (r < 92) begin
      v = longint'($signed($urandom));
    end else begin
      v = longint'({32'd0, $urandom});
      if ($urandom_range(1)) v = -v;
    end
    if (v < 0) line_buf.push_back(CH_MINUS);
    else if ($urandom_range(4) == 0) line_buf.push_back(CH_PLUS);
    mag = (v < 0) ? -v : v;
    if ($urandom_range(9) == 0) repeat ($urandom_range(1, 16)) line_buf.push_back(CH_ZERO);
    txt = $sformatf("%0d", mag);
    for (int i = 0; i < txt.len(); i++) line_buf.push_back(txt[i]);
    if ($urandom_range(19) == 0) line_buf.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void make_line();
    int n;
    int sel;
    int pos;
    line_buf.delete();
    sel = $urandom_range(99);
    if (sel < 5) begin
      repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(255)));
      return;
    end
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) line_buf.push_back(ws_char());
      add_number();
      if ($urandom_range(3) == 0) line_buf.push_back(ws_char());
      if (i < n - 1) line_buf.push_back(CH_COMMA);
    end
    if (sel < 30) begin
      pos = $urandom_range(line_buf.size() - 1);
      case ($urandom_range(3))
        0: line_buf[pos] = junk_char();
        1: line_buf.insert(pos, junk_char());
        2: if (line_buf.size() > 1) line_buf.delete(pos);
        default: line_buf.push_back(CH_COMMA);
      endcase
    end
  endfunction

  initial begin
    int unsigned target;
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_MAX_VALUE;
    cfg_data       <= '0;
    chars_if.valid <= 1'b0;
    chars_if.ch    <= '0;
    chars_if.last  <= 1'b0;
    steady = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset limits: empty list, leading comma, lone sign, single number, missing comma,
    // trailing comma, stray char in a token, both limits
    send_text(" ");
    send_text(",");
    send_text("-");
    send_text("7");
    send_text("1 2");
    send_text("1,");
    send_text("9x");
    send_text("-16384,+16383");
    wait_idle();

    apply_limits(32'h7FFF_FFFF, 32'h8000_0000);
    send_long_list(MAX_ITEMS);
    send_long_list(MAX_ITEMS + 1);
    wait_idle();

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      steady = (s == 2);
      case (s)
        0: apply_limits(MAX_VALUE_RESET, MIN_VALUE_RESET);
        1: apply_limits(32'h7FFF_FFFF, 32'h8000_0000);
        2: apply_limits(32'd9, -32'sd9);
        3: apply_limits(-32'sd5, 32'sd5);        // inverted window
        4: apply_limits($urandom, $urandom);
        default: apply_limits(32'h8000_0000, 32'h8000_0000);
      endcase
      target = chars_sent + CHARS_PER_STEP;
      while (chars_sent < target) begin
        make_line();
        send_line();
        if ($urandom_range(7) == 0) wait_idle();
      end
      wait_idle();
    end
    steady = 1'b0;

    wait_idle();
    $display("covered %0d chars in %0d lines under %0d limit settings",
             chars_sent, lines_sent, NUM_SETTINGS + 2);
    $display("numbers %0d, lists accepted %0d, lists rejected %0d, mismatches %0d",
             sb.numbers_seen, sb.lists_accepted, sb.lists_rejected, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("decimal_list_parser regression: pass");
    else
      $display("decimal_list_parser regression: fail");
    $finish;
  end

endmodule
